FILE: rtl/utu_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
`timescale 1ns / 1ps

package utu_pkg;

   // Window and result limits
   localparam int unsigned WIN_DEPTH = 4;
   localparam logic [2:0]  MAX_UNITS = 3'd4;

   // Code point constants
   localparam logic [15:0] REPL_UNIT    = 16'hFFFD;
   localparam logic [20:0] CP_MAX       = 21'h10FFFF;
   localparam logic [20:0] CP_BMP_MAX   = 21'h00FFFF;
   localparam logic [20:0] CP_SUR_LO    = 21'h00D800;
   localparam logic [20:0] CP_SUR_HI    = 21'h00DFFF;
   localparam logic [20:0] CP_SUPP_BASE = 21'h010000;
   localparam logic [20:0] MIN_LEN2     = 21'h000080;
   localparam logic [20:0] MIN_LEN3     = 21'h000800;
   localparam logic [20:0] MIN_LEN4     = 21'h010000;
   localparam logic [5:0]  HI_SUR_TAG   = 6'b110110;
   localparam logic [5:0]  LO_SUR_TAG   = 6'b110111;

   // One request: a byte of UTF-8 text
   typedef struct packed {
      logic [7:0] data_byte;
      logic       text_end;
   } req_data_type;

   // One result: a UTF-16 code unit
   typedef struct packed {
      logic [15:0] code_unit;
      logic        run_last;
      logic        text_done;
   } rsp_data_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PAIR,
      ST_FINISH
   } seq_state_type;

   // What the scan unit decided for the front of the window
   typedef enum logic [1:0] {
      ACT_BAD,
      ACT_WAIT,
      ACT_UNIT,
      ACT_PAIR
   } scan_action_type;

   typedef struct packed {
      scan_action_type action;
      logic [15:0]     unit_hi;
      logic [15:0]     unit_lo;
      logic [2:0]      drop;
   } scan_result_type;

endpackage

FILE: rtl/utu_scan.sv
// Window scan unit: checks and decodes the sequence at the front of the byte window.
`timescale 1ns / 1ps

module utu_scan (
   input  logic [3:0][7:0]          window,
   input  logic [2:0]               count,
   output utu_pkg::scan_result_type result
);

   logic [7:0]  lead;
   logic [2:0]  seq_len;
   logic        lead_ok;
   logic [20:0] cp;
   logic [20:0] cp_min;
   logic        cont_ok;
   logic        range_bad;
   logic [20:0] supp_off;

   // Classify the lead byte and assemble the code point
   always_comb begin
      lead    = window[0];
      lead_ok = 1'b1;
      seq_len = 3'd1;
      cp_min  = 21'd0;
      cp      = {14'd0, lead[6:0]};
      cont_ok = 1'b1;
      if (lead[7] == 1'b0) begin
         seq_len = 3'd1;
         cp      = {14'd0, lead[6:0]};
      end else if (lead[7:5] == 3'b110) begin
         seq_len = 3'd2;
         cp_min  = utu_pkg::MIN_LEN2;
         cp      = {10'd0, lead[4:0], window[1][5:0]};
         cont_ok = (window[1][7:6] == 2'b10);
      end else if (lead[7:4] == 4'b1110) begin
         seq_len = 3'd3;
         cp_min  = utu_pkg::MIN_LEN3;
         cp      = {5'd0, lead[3:0], window[1][5:0], window[2][5:0]};
         cont_ok = (window[1][7:6] == 2'b10) && (window[2][7:6] == 2'b10);
      end else if (lead[7:3] == 5'b11110) begin
         seq_len = 3'd4;
         cp_min  = utu_pkg::MIN_LEN4;
         cp      = {lead[2:0], window[1][5:0], window[2][5:0], window[3][5:0]};
         cont_ok = (window[1][7:6] == 2'b10) && (window[2][7:6] == 2'b10)
                   && (window[3][7:6] == 2'b10);
      end else begin
         lead_ok = 1'b0;
      end
   end

   // Reject overlong forms, surrogates and values past the last code point
   assign range_bad = (cp < cp_min) || (cp > utu_pkg::CP_MAX)
                      || ((cp >= utu_pkg::CP_SUR_LO) && (cp <= utu_pkg::CP_SUR_HI));

   assign supp_off = cp - utu_pkg::CP_SUPP_BASE;

   // Pick the action for this step
   always_comb begin
      result.action  = utu_pkg::ACT_BAD;
      result.unit_hi = utu_pkg::REPL_UNIT;
      result.unit_lo = {utu_pkg::LO_SUR_TAG, supp_off[9:0]};
      result.drop    = 3'd1;
      if (!lead_ok) begin
         result.action = utu_pkg::ACT_BAD;
      end else if (count < seq_len) begin
         result.action = utu_pkg::ACT_WAIT;
      end else if (!cont_ok || range_bad) begin
         result.action = utu_pkg::ACT_BAD;
      end else if (cp <= utu_pkg::CP_BMP_MAX) begin
         result.action  = utu_pkg::ACT_UNIT;
         result.unit_hi = cp[15:0];
         result.drop    = seq_len;
      end else begin
         result.action  = utu_pkg::ACT_PAIR;
         result.unit_hi = {utu_pkg::HI_SUR_TAG, supp_off[19:10]};
         result.drop    = seq_len;
      end
   end

endmodule

FILE: rtl/utf8_to_utf16_transcoder.sv
// Top level of the UTF-8 to UTF-16 transcoder: byte window, sequencer and result register.
`timescale 1ns / 1ps

// Takes one UTF-8 byte per request and returns zero to four UTF-16 code units,
// the last of which carries run_last (and text_done when the byte ends the text).
// Bytes wait in a four-byte window; one scan unit resolves the sequence at the
// front of the window in each cycle unless rsp_stall holds the result register.
// A byte passes through an accept step, one scan step per unit given (up to four
// after a bad continuation), one more for the low half of a surrogate pair, one
// scan step that finds the window empty, the sequence incomplete or the unit
// limit reached (it also gives the replacement when the text ends inside a
// sequence) and a closing step, plus any wait while rsp_stall holds the result
// register. req_stall is high until the byte is fully handled.
module utf8_to_utf16_transcoder (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  utu_pkg::req_data_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output utu_pkg::rsp_data_type rsp_data
);

   utu_pkg::seq_state_type   state_ff, state_in;
   logic [3:0][7:0]          win_ff, win_in;
   logic [2:0]               count_ff, count_in;
   logic [2:0]               nres_ff, nres_in;
   logic                     end_ff, end_in;
   logic                     pend_valid_ff, pend_valid_in;
   logic [15:0]              pend_unit_ff, pend_unit_in;
   logic [15:0]              lo_unit_ff, lo_unit_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   utu_pkg::rsp_data_type    rsp_data_ff, rsp_data_in;
   utu_pkg::scan_result_type scan;
   logic                     out_free;
   logic                     push_ok;
   logic                     scan_done;
   logic [3:0][7:0]          win_shift;
   logic [2:0]               count_shift;

   utu_scan u_scan (
      .window (win_ff),
      .count  (count_ff),
      .result (scan)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign push_ok   = !pend_valid_ff || out_free;
   assign scan_done = (count_ff == 3'd0) || (nres_ff == utu_pkg::MAX_UNITS);

   // Drop the resolved bytes from the front of the window
   always_comb begin
      logic [2:0] src;
      win_shift = win_ff;
      for (int i = 0; i < 4; i++) begin
         src = 3'(i) + scan.drop;
         if (src < 3'd4) begin
            win_shift[i] = win_ff[src[1:0]];
         end
      end
      count_shift = (count_ff > scan.drop) ? (count_ff - scan.drop) : 3'd0;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         utu_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = utu_pkg::ST_SCAN;
            end
         end
         utu_pkg::ST_SCAN: begin
            if (scan_done) begin
               state_in = utu_pkg::ST_FINISH;
            end else begin
               case (scan.action)
                  utu_pkg::ACT_WAIT: begin
                     if (!end_ff || push_ok) begin
                        state_in = utu_pkg::ST_FINISH;
                     end
                  end
                  utu_pkg::ACT_PAIR: begin
                     if (push_ok) begin
                        state_in = utu_pkg::ST_PAIR;
                     end
                  end
                  default: state_in = utu_pkg::ST_SCAN;
               endcase
            end
         end
         utu_pkg::ST_PAIR: begin
            if (nres_ff == utu_pkg::MAX_UNITS || push_ok) begin
               state_in = utu_pkg::ST_SCAN;
            end
         end
         utu_pkg::ST_FINISH: begin
            if (!pend_valid_ff || out_free) begin
               state_in = utu_pkg::ST_IDLE;
            end
         end
         default: state_in = utu_pkg::ST_IDLE;
      endcase
   end

   // Datapath and output register updates
   always_comb begin
      logic        do_push;
      logic [15:0] push_unit;
      logic [1:0]  widx;
      win_in        = win_ff;
      count_in      = count_ff;
      nres_in       = nres_ff;
      end_in        = end_ff;
      pend_valid_in = pend_valid_ff;
      pend_unit_in  = pend_unit_ff;
      lo_unit_in    = lo_unit_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      do_push       = 1'b0;
      push_unit     = scan.unit_hi;
      widx          = (count_ff > 3'd3) ? 2'd3 : count_ff[1:0];
      case (state_ff)
         utu_pkg::ST_IDLE: begin
            // Append the request byte to the window
            if (req_valid) begin
               win_in[widx] = req_data.data_byte;
               count_in     = {1'b0, widx} + 3'd1;
               nres_in      = 3'd0;
               end_in       = req_data.text_end;
            end
         end
         utu_pkg::ST_SCAN: begin
            if (!scan_done && push_ok) begin
               case (scan.action)
                  utu_pkg::ACT_WAIT: begin
                     // Text ends inside a sequence: one replacement, drop the rest
                     if (end_ff) begin
                        do_push   = 1'b1;
                        push_unit = utu_pkg::REPL_UNIT;
                        count_in  = 3'd0;
                     end
                  end
                  utu_pkg::ACT_PAIR: begin
                     do_push    = 1'b1;
                     lo_unit_in = scan.unit_lo;
                     win_in     = win_shift;
                     count_in   = count_shift;
                  end
                  default: begin
                     do_push  = 1'b1;
                     win_in   = win_shift;
                     count_in = count_shift;
                  end
               endcase
            end
         end
         utu_pkg::ST_PAIR: begin
            if (nres_ff != utu_pkg::MAX_UNITS && push_ok) begin
               do_push   = 1'b1;
               push_unit = lo_unit_ff;
            end
         end
         utu_pkg::ST_FINISH: begin
            // Release the held unit marked as the last of this request
            if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  rsp_valid_in          = 1'b1;
                  rsp_data_in.code_unit = pend_unit_ff;
                  rsp_data_in.run_last  = 1'b1;
                  rsp_data_in.text_done = end_ff;
                  pend_valid_in         = 1'b0;
               end
               if (end_ff) begin
                  count_in = 3'd0;
               end
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
      // Hold the new unit; move the previously held one out
      if (do_push) begin
         if (pend_valid_ff) begin
            rsp_valid_in          = 1'b1;
            rsp_data_in.code_unit = pend_unit_ff;
            rsp_data_in.run_last  = 1'b0;
            rsp_data_in.text_done = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_unit_in  = push_unit;
         nres_in       = nres_ff + 3'd1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= utu_pkg::ST_IDLE;
         count_ff      <= 3'd0;
         nres_ff       <= 3'd0;
         end_ff        <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         nres_ff       <= nres_in;
         end_ff        <= end_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      win_ff       <= win_in;
      pend_unit_ff <= pend_unit_in;
      lo_unit_ff   <= lo_unit_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign req_stall = (state_ff != utu_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: verif/utf8_to_utf16_checker.sv
// Checker for the UTF-8 to UTF-16 transcoder: predicts code units and compares them.
`timescale 1ns / 1ps

module utf8_to_utf16_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  utu_pkg::req_data_type req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  utu_pkg::rsp_data_type rsp_data,
   output int                    fail_count,
   output int                    pending
);

   // Predicted byte window
   logic [7:0]   win_bytes [utu_pkg::WIN_DEPTH];
   int           win_fill = 0;

   // Units of the current request, and units still owed by the block
   utu_pkg::rsp_data_type step_units [$];
   utu_pkg::rsp_data_type units_due  [$];
   int                    mismatches = 0;

   assign fail_count = mismatches;

   task automatic report(input string msg);
      $display("[%0t] checker: %s", $time, msg);
      mismatches++;
   endtask

   // Drop k bytes from the front of the window
   function automatic void shift_window(input int k);
      if (k >= win_fill) begin
         win_fill = 0;
      end else begin
         for (int i = 0; i < win_fill - k; i++) begin
            win_bytes[i] = win_bytes[i + k];
         end
         win_fill = win_fill - k;
      end
   endfunction

   // Append one unit, capped at the block's result limit
   function automatic void add_unit(input logic [15:0] value);
      utu_pkg::rsp_data_type u;
      u = '0;
      u.code_unit = value;
      if (step_units.size() < utu_pkg::MAX_UNITS) begin
         step_units = {step_units, u};
      end
   endfunction

   // Work out the units that one request makes decidable
   task automatic decode_byte(input utu_pkg::req_data_type req);
      logic [7:0]  lead;
      logic [20:0] cp;
      logic [20:0] min_cp;
      logic [20:0] offset;
      int          len;
      int          last;
      logic        ok;
      step_units.delete();
      if (win_fill > 3) begin
         win_fill = 3;
      end
      win_bytes[win_fill] = req.data_byte;
      win_fill++;

      while (win_fill > 0 && step_units.size() < utu_pkg::MAX_UNITS) begin
         lead = win_bytes[0];
         if (lead[7] == 1'b0) begin
            cp = {14'd0, lead[6:0]};
            len = 1;
            min_cp = '0;
         end else if (lead[7:5] == 3'b110) begin
            cp = {16'd0, lead[4:0]};
            len = 2;
            min_cp = utu_pkg::MIN_LEN2;
         end else if (lead[7:4] == 4'b1110) begin
            cp = {17'd0, lead[3:0]};
            len = 3;
            min_cp = utu_pkg::MIN_LEN3;
         end else if (lead[7:3] == 5'b11110) begin
            cp = {18'd0, lead[2:0]};
            len = 4;
            min_cp = utu_pkg::MIN_LEN4;
         end else begin
            // bad lead byte: replace and drop it
            add_unit(utu_pkg::REPL_UNIT);
            shift_window(1);
            continue;
         end

         // sequence not complete yet; at end of text it becomes one replacement
         if (win_fill < len) begin
            if (req.text_end) begin
               add_unit(utu_pkg::REPL_UNIT);
               win_fill = 0;
            end
            break;
         end

         ok = 1'b1;
         for (int k = 1; k < len; k++) begin
            if (win_bytes[k][7:6] != 2'b10) begin
               ok = 1'b0;
               break;
            end
            cp = {cp[14:0], win_bytes[k][5:0]};
         end

         // bad continuation, overlong, surrogate or out of range: drop the lead only
         if (!ok || cp < min_cp || cp > utu_pkg::CP_MAX ||
             (cp >= utu_pkg::CP_SUR_LO && cp <= utu_pkg::CP_SUR_HI)) begin
            add_unit(utu_pkg::REPL_UNIT);
            shift_window(1);
            continue;
         end

         if (cp <= utu_pkg::CP_BMP_MAX) begin
            add_unit(cp[15:0]);
         end else begin
            offset = cp - utu_pkg::CP_SUPP_BASE;
            add_unit({utu_pkg::HI_SUR_TAG, offset[19:10]});
            add_unit({utu_pkg::LO_SUR_TAG, offset[9:0]});
         end
         shift_window(len);
      end

      if (req.text_end) begin
         win_fill = 0;
      end

      if (step_units.size() > 0) begin
         last = step_units.size() - 1;
         step_units[last].run_last = 1'b1;
         step_units[last].text_done = req.text_end;
      end
      foreach (step_units[i]) begin
         units_due = {units_due, step_units[i]};
      end
   endtask

   // Compare accepted units, then predict for an accepted request
   always @(posedge clock) begin : watch
      utu_pkg::rsp_data_type oldest;
      if (reset) begin
         win_fill = 0;
         units_due.delete();
         pending <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (units_due.size() == 0) begin
               report($sformatf("unit %h with nothing outstanding", rsp_data.code_unit));
            end else begin
               oldest = units_due.pop_front();
               if (rsp_data.code_unit !== oldest.code_unit) begin
                  report($sformatf("code_unit %h, predicted %h",
                                   rsp_data.code_unit, oldest.code_unit));
               end
               if (rsp_data.run_last !== oldest.run_last) begin
                  report($sformatf("run_last %b, predicted %b on unit %h",
                                   rsp_data.run_last, oldest.run_last, oldest.code_unit));
               end
               if (rsp_data.text_done !== oldest.text_done) begin
                  report($sformatf("text_done %b, predicted %b on unit %h",
                                   rsp_data.text_done, oldest.text_done, oldest.code_unit));
               end
            end
         end
         if (req_valid && !req_stall) begin
            decode_byte(req_data);
         end
         pending <= units_due.size();
      end
   end

endmodule

FILE: verif/utf8_to_utf16_transcoder_tb.sv
// Testbench top for the UTF-8 to UTF-16 transcoder: byte stimulus, stall pattern and verdict.
`timescale 1ns / 1ps

module utf8_to_utf16_transcoder_tb;

   localparam int RANDOM_BYTES = 500;
   localparam int IDLE_LIMIT   = 2000;
   localparam int SETTLE_WAIT  = 64;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_SPARSE,
      STALL_BEAT,
      STALL_HEAVY
   } stall_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   utu_pkg::req_data_type req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   utu_pkg::rsp_data_type rsp_data;
   int                    fail_count;
   int                    pending;

   stall_mode_type stall_mode = STALL_NONE;
   int             stall_left = 0;
   int             beat_count = 0;
   int             quiet_cycles = 0;
   int             burst_left = 0;
   int             sent_count = 0;
   logic [7:0]     text_q [$];
   logic [8:0]     directed [23];

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   utf8_to_utf16_transcoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   utf8_to_utf16_checker unit_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // Receiver: switch between stall patterns at random
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_left <= $urandom_range(20, 120);
      end else begin
         stall_left <= stall_left - 1;
      end
      beat_count <= beat_count + 1;
      case (stall_mode)
         STALL_NONE:   rsp_stall <= 1'b0;
         STALL_SPARSE: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_BEAT:   rsp_stall <= (beat_count % 7 < 4);
         default:      rsp_stall <= ($urandom_range(0, 4) != 0);
      endcase
   end

   // Watchdog: end the run when no handshake happens for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
         $display("utf8_to_utf16_transcoder: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Send one request; hold it until accepted, then maybe idle between bursts
   task automatic push_request(input logic [7:0] data_byte, input logic text_end);
      int gap;
      req_data <= {data_byte, text_end};
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Hold the sender until every predicted unit has come back
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // Append one UTF-8 sequence, valid or malformed, or a noise byte
   task automatic add_piece();
      logic [7:0]  seq [$];
      logic [20:0] cp;
      logic [7:0]  junk;
      int          pick;
      int          len;
      int          cut;
      int          pos;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         len = 1;
         cp = 21'($urandom_range(0, 'h7F));
      end else if (pick < 45) begin
         len = 2;
         cp = 21'($urandom_range('h80, 'h7FF));
      end else if (pick < 60) begin
         len = 3;
         cp = 21'($urandom_range('h800, 'hFFFF));
      end else if (pick < 72) begin
         len = 4;
         cp = 21'($urandom_range('h10000, 'h10FFFF));
      end else if (pick < 78) begin
         // overlong form
         len = $urandom_range(2, 4);
         cp = (len == 2) ? 21'($urandom_range(0, 'h7F)) :
              (len == 3) ? 21'($urandom_range(0, 'h7FF)) :
                           21'($urandom_range(0, 'hFFFF));
      end else if (pick < 82) begin
         // encoded surrogate
         len = 3;
         cp = 21'($urandom_range('hD800, 'hDFFF));
      end else if (pick < 86) begin
         // above the last code point
         len = 4;
         cp = 21'($urandom_range('h110000, 'h1FFFFF));
      end else begin
         len = 0;
         cp = '0;
      end

      case (len)
         0: seq = {seq, 8'($urandom_range(0, 255))};
         1: seq = {seq, {1'b0, cp[6:0]}};
         2: begin
            seq = {seq, {3'b110, cp[10:6]}};
            seq = {seq, {2'b10, cp[5:0]}};
         end
         3: begin
            seq = {seq, {4'b1110, cp[15:12]}};
            seq = {seq, {2'b10, cp[11:6]}};
            seq = {seq, {2'b10, cp[5:0]}};
         end
         default: begin
            seq = {seq, {5'b11110, cp[20:18]}};
            seq = {seq, {2'b10, cp[17:12]}};
            seq = {seq, {2'b10, cp[11:6]}};
            seq = {seq, {2'b10, cp[5:0]}};
         end
      endcase

      // break some sequences: cut them short or spoil a continuation byte
      if (seq.size() > 1) begin
         case ($urandom_range(0, 9))
            0: begin
               cut = $urandom_range(1, seq.size() - 1);
               while (seq.size() > cut) void'(seq.pop_back());
            end
            1: begin
               pos = $urandom_range(1, seq.size() - 1);
               junk = 8'($urandom_range(0, 255));
               if (junk[7:6] == 2'b10) begin
                  junk[6] = 1'b1;
               end
               seq[pos] = junk;
            end
            default: ;
         endcase
      end
      foreach (seq[i]) begin
         text_q = {text_q, seq[i]};
      end
   endtask

   initial begin : stimulus
      int   pieces;
      logic paused;
      paused = 1'b0;
      // {text_end, data_byte}
      directed = '{9'h000, 9'h17F,                   // ASCII extremes, end of a text
                   9'h0C2, 9'h080,                   // lowest two-byte value
                   9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,   // highest code point
                   9'h080, 9'h0FF,                   // bad lead bytes
                   9'h0C3, 9'h041,                   // bad continuation
                   9'h0C0, 9'h080,                   // overlong
                   9'h0ED, 9'h0A0, 9'h080,           // surrogate
                   9'h0F4, 9'h090, 9'h080, 9'h080,   // above the last code point
                   9'h0E2, 9'h182};                  // text ends inside a sequence

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         push_request(directed[i][7:0], directed[i][8]);
      end
      drain();

      // Random texts, mostly well formed
      while (sent_count < RANDOM_BYTES) begin
         text_q.delete();
         pieces = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
         repeat (pieces) add_piece();
         foreach (text_q[i]) begin
            push_request(text_q[i], i == text_q.size() - 1);
            sent_count++;
         end
         if (!paused && sent_count >= RANDOM_BYTES / 2) begin
            paused = 1'b1;
            drain();
         end
      end

      drain();
      repeat (SETTLE_WAIT) @(posedge clock);
      if (fail_count == 0) begin
         $display("utf8_to_utf16_transcoder: match");
      end else begin
         $display("utf8_to_utf16_transcoder: mismatch");
      end
      $finish;
   end

endmodule
